@@ hdl/pmm_pkg.sv @@
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the page allocator
// Table sizes, page geometry, operation codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package pmm_pkg;

  localparam int MAX_RANGES  = 32;
  localparam int MAX_ENTRIES = 128;
  localparam int PAGE_SHIFT  = 12;
  localparam logic [31:0] PHYS_LIMIT = 32'hFFFF_F000;

  localparam logic [31:0] PG_SIZE = 32'(64'd1 << PAGE_SHIFT);
  localparam logic [31:0] PG_MASK = PG_SIZE - 32'd1;

  // index and counter widths
  localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int BIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_RANGES + 1) + 1;
  localparam int BCW = $clog2(MAX_ENTRIES + 1);

  localparam int CNT_W = 21;

  typedef enum logic [2:0] {
    OP_ENTRY   = 3'd0,
    OP_BUILD   = 3'd1,
    OP_ALLOC   = 3'd2,
    OP_HANDOFF = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ENT1, ST_ENT2, ST_ENT3,
    ST_B_START, ST_SORT_LD, ST_SORT_LDW, ST_SORT_CHK, ST_SORT_CMP,
    ST_MRG_0, ST_MRG_0W, ST_MRG_LD, ST_MRG_W, ST_MRG_END,
    ST_CUT_J, ST_CUT_JW, ST_CUT_I, ST_CUT_IW,
    ST_DROP, ST_DROPW, ST_SPL, ST_SPLW, ST_SPL_A, ST_SPL_B,
    ST_SUM, ST_SUMW,
    ST_AL_CHK, ST_AL_LD, ST_AL_W, ST_AL_NS, ST_AL_NSW,
    ST_RD, ST_RDW, ST_DONE
  } state_t;

  typedef struct packed {
    logic              status;
    logic [31:0]       page_address;
    logic [31:0]       range_start;
    logic [31:0]       range_end;
    logic [31:0]       allocated_end;
    logic [CNT_W-1:0]  total_pages;
    logic [CNT_W-1:0]  free_pages;
    logic [5:0]        range_count;
  } result_t;

  function automatic logic [31:0] pg_down(input logic [31:0] v);
    pg_down = v & ~PG_MASK;
  endfunction

  function automatic logic [31:0] pg_up(input logic [31:0] v);
    logic [32:0] sum;
    sum = {1'b0, v} + {1'b0, PG_MASK};
    if (sum > {1'b0, PHYS_LIMIT}) pg_up = PHYS_LIMIT;
    else pg_up = sum[31:0] & ~PG_MASK;
  endfunction

endpackage

@@ hdl/pmm_ram.sv @@
// ----------------------------------------------------------------------------
// pmm_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/pmm_core.sv @@
// ----------------------------------------------------------------------------
// pmm_core: table sequencer of the page allocator
// One compare/add datapath walks the tables, one step a cycle unless stalled.
// ----------------------------------------------------------------------------
module pmm_core import pmm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   kernel_end_addr,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_op,
  input  logic [31:0]   in_base_low,
  input  logic [31:0]   in_base_high,
  input  logic [31:0]   in_length_low,
  input  logic [31:0]   in_length_high,
  input  logic [31:0]   in_entry_type,
  input  logic [5:0]    in_range_index,
  input  logic          out_free,
  output logic          res_push,
  output result_t       res
);

  state_t state, state_next;

  op_t          op;
  logic [31:0]  bl, bh, ll, lh, typ;
  logic [5:0]   idx;
  logic [CW-1:0]  cnt, ptr, i, m, outp;
  logic [BCW-1:0] bcnt, seen, j;
  logic [31:0]  nxt, cs, ce, bs, be, endr, sum;
  logic [CNT_W-1:0] ptot, pfree;
  logic         lerr, hoff, mpass;
  logic         st;
  logic [31:0]  pa, rs, re, ae;

  logic           u_we, b_we;
  logic [RIW-1:0] u_waddr, u_raddr;
  logic [BIW-1:0] b_waddr, b_raddr;
  logic [63:0]    u_wdata, u_rdata, b_wdata, b_rdata;
  logic [31:0]    ud_s, ud_e, kup, s2, lim;
  logic           use_r, dis, ent_ok;
  logic [32:0]    nx;
  logic [CW-1:0]  mm1, ip1;

  assign ud_s = u_rdata[31:0];
  assign ud_e = u_rdata[63:32];
  assign kup  = pg_up(kernel_end_addr);
  assign s2   = (cs < kup) ? kup : cs;
  assign use_r = (typ == 32'd1);
  assign lim  = PHYS_LIMIT - bl;
  assign dis  = (be <= ud_s) || (bs >= ud_e);
  assign nx   = {1'b0, nxt} + {1'b0, PG_SIZE};
  assign mm1  = m - CW'(1);
  assign ip1  = i + CW'(1);
  assign ent_ok = use_r ? ((cs < ce) && (s2 < ce)) : (cs < ce);

  assign in_ready = (state == ST_IDLE);

  pmm_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_usable (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  pmm_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_blocked (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  always_comb begin
    res.status        = (op == OP_ENTRY) ? lerr : st;
    res.page_address  = pa;
    res.range_start   = rs;
    res.range_end     = re;
    res.allocated_end = ae;
    res.total_pages   = ptot;
    res.free_pages    = pfree;
    res.range_count   = 6'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and table ports
  always_comb begin
    state_next = state;
    u_we = 1'b0; u_waddr = '0; u_wdata = '0; u_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
    res_push = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ENTRY:   state_next = ST_ENT1;
            OP_BUILD:   state_next = ST_B_START;
            OP_ALLOC:   state_next = ST_AL_CHK;
            OP_READ:    state_next = ST_RD;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_ENT1: begin
        if (seen >= BCW'(MAX_ENTRIES) || lerr || bh != 32'd0 || bl >= PHYS_LIMIT)
          state_next = ST_DONE;
        else
          state_next = ST_ENT2;
      end
      ST_ENT2: state_next = (endr <= bl) ? ST_DONE : ST_ENT3;
      ST_ENT3: begin
        state_next = ST_DONE;
        if (ent_ok) begin
          if (use_r && cnt < CW'(MAX_RANGES)) begin
            u_we = 1'b1; u_waddr = RIW'(cnt); u_wdata = {ce, s2};
          end else if (!use_r && bcnt < BCW'(MAX_ENTRIES)) begin
            b_we = 1'b1; b_waddr = BIW'(bcnt); b_wdata = {ce, cs};
          end
        end
      end
      ST_B_START: state_next = lerr ? ST_DONE : ST_SORT_LD;
      ST_SORT_LD: begin
        if (i >= cnt) state_next = ST_MRG_0;
        else begin
          u_raddr = RIW'(i); state_next = ST_SORT_LDW;
        end
      end
      ST_SORT_LDW: state_next = ST_SORT_CHK;
      ST_SORT_CHK: begin
        if (m == '0) begin
          u_we = 1'b1; u_waddr = RIW'(m); u_wdata = {ce, cs};
          state_next = ST_SORT_LD;
        end else begin
          u_raddr = RIW'(mm1); state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        u_we = 1'b1; u_waddr = RIW'(m);
        if (ud_s > cs) begin
          u_wdata = u_rdata; state_next = ST_SORT_CHK;
        end else begin
          u_wdata = {ce, cs}; state_next = ST_SORT_LD;
        end
      end
      ST_MRG_0: begin
        if (cnt == '0) state_next = ST_MRG_END;
        else begin
          u_raddr = '0; state_next = ST_MRG_0W;
        end
      end
      ST_MRG_0W: state_next = ST_MRG_LD;
      ST_MRG_LD: begin
        if (i >= cnt) begin
          u_we = 1'b1; u_waddr = RIW'(outp); u_wdata = {ce, cs};
          state_next = ST_MRG_END;
        end else begin
          u_raddr = RIW'(i); state_next = ST_MRG_W;
        end
      end
      ST_MRG_W: begin
        if (ud_s > ce) begin
          u_we = 1'b1; u_waddr = RIW'(outp); u_wdata = {ce, cs};
        end
        state_next = ST_MRG_LD;
      end
      ST_MRG_END: begin
        if (!mpass) state_next = ST_CUT_J;
        else if (cnt == '0) state_next = ST_DONE;
        else state_next = ST_SUM;
      end
      ST_CUT_J: begin
        if (j >= bcnt) state_next = ST_MRG_0;
        else begin
          b_raddr = BIW'(j); state_next = ST_CUT_JW;
        end
      end
      ST_CUT_JW: state_next = ST_CUT_I;
      ST_CUT_I: begin
        if (i >= cnt) state_next = ST_CUT_J;
        else begin
          u_raddr = RIW'(i); state_next = ST_CUT_IW;
        end
      end
      ST_CUT_IW: begin
        state_next = ST_CUT_I;
        if (!dis) begin
          if (bs <= ud_s) begin
            if (be >= ud_e) state_next = ST_DROP;
            else begin
              u_we = 1'b1; u_waddr = RIW'(i); u_wdata = {ud_e, be};
            end
          end else if (be >= ud_e) begin
            u_we = 1'b1; u_waddr = RIW'(i); u_wdata = {bs, ud_s};
          end else if (cnt >= CW'(MAX_RANGES)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SPL;
          end
        end
      end
      ST_DROP: begin
        if (m >= cnt) state_next = ST_CUT_I;
        else begin
          u_raddr = RIW'(m); state_next = ST_DROPW;
        end
      end
      ST_DROPW: begin
        u_we = 1'b1; u_waddr = RIW'(mm1); u_wdata = u_rdata;
        state_next = ST_DROP;
      end
      ST_SPL: begin
        if (m <= ip1) state_next = ST_SPL_A;
        else begin
          u_raddr = RIW'(mm1); state_next = ST_SPLW;
        end
      end
      ST_SPLW: begin
        u_we = 1'b1; u_waddr = RIW'(m); u_wdata = u_rdata;
        state_next = ST_SPL;
      end
      ST_SPL_A: begin
        u_we = 1'b1; u_waddr = RIW'(ip1); u_wdata = {ce, be};
        state_next = ST_SPL_B;
      end
      ST_SPL_B: begin
        u_we = 1'b1; u_waddr = RIW'(i); u_wdata = {bs, cs};
        state_next = ST_CUT_I;
      end
      ST_SUM: begin
        if (i >= cnt) state_next = ST_DONE;
        else begin
          u_raddr = RIW'(i); state_next = ST_SUMW;
        end
      end
      ST_SUMW: state_next = ST_SUM;
      ST_AL_CHK: state_next = hoff ? ST_DONE : ST_AL_LD;
      ST_AL_LD: begin
        if (ptr >= cnt) state_next = ST_DONE;
        else begin
          u_raddr = RIW'(ptr); state_next = ST_AL_W;
        end
      end
      ST_AL_W: state_next = (nxt < ud_e) ? ST_DONE : ST_AL_NS;
      ST_AL_NS: begin
        if (ptr >= cnt) state_next = ST_DONE;
        else begin
          u_raddr = RIW'(ptr); state_next = ST_AL_NSW;
        end
      end
      ST_AL_NSW: state_next = ST_AL_LD;
      ST_RD: begin
        if (32'(idx) >= 32'(cnt)) state_next = ST_DONE;
        else begin
          u_raddr = RIW'(idx); state_next = ST_RDW;
        end
      end
      ST_RDW: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          res_push = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; bcnt <= '0; seen <= '0; ptr <= '0; nxt <= '0;
      ptot <= '0; pfree <= '0; lerr <= 1'b0; hoff <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_ENTRY) begin
              hoff <= 1'b1; ptot <= '0; pfree <= '0;
            end else if (in_op == OP_HANDOFF) begin
              hoff <= 1'b1;
            end else if (in_op == OP_BUILD) begin
              hoff <= 1'b1; ptot <= '0; pfree <= '0; ptr <= '0; nxt <= '0;
            end
          end
        end
        ST_ENT1: if (seen < BCW'(MAX_ENTRIES)) seen <= seen + BCW'(1);
        ST_ENT3: begin
          if (ent_ok) begin
            if (use_r) begin
              if (cnt < CW'(MAX_RANGES)) cnt <= cnt + CW'(1);
              else lerr <= 1'b1;
            end else begin
              if (bcnt < BCW'(MAX_ENTRIES)) bcnt <= bcnt + BCW'(1);
              else lerr <= 1'b1;
            end
          end
        end
        ST_MRG_LD: if (i >= cnt) cnt <= outp + CW'(1);
        ST_DROP: if (m >= cnt) cnt <= cnt - CW'(1);
        ST_SPL_B: cnt <= cnt + CW'(1);
        ST_SUM: begin
          if (i >= cnt) begin
            ptot <= sum[CNT_W-1:0]; pfree <= sum[CNT_W-1:0]; hoff <= 1'b0;
          end
        end
        ST_SUMW: if (i == '0) nxt <= ud_s;
        ST_AL_W: begin
          if (nxt < ud_e) begin
            nxt <= (nx > {1'b0, ud_e}) ? ud_e : nx[31:0];
            if (pfree != '0) pfree <= pfree - CNT_W'(1);
          end else begin
            ptr <= ptr + CW'(1);
          end
        end
        ST_AL_NSW: nxt <= ud_s;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op <= op_t'(in_op);
          bl <= in_base_low; bh <= in_base_high;
          ll <= in_length_low; lh <= in_length_high;
          typ <= in_entry_type; idx <= in_range_index;
          st <= (in_op > OP_READ); pa <= '0; rs <= '0; re <= '0; ae <= '0;
        end
      end
      ST_ENT1: endr <= (lh != 32'd0 || ll > lim) ? PHYS_LIMIT : bl + ll;
      ST_ENT2: begin
        if (use_r) begin
          cs <= pg_up(bl); ce <= pg_down(endr);
        end else begin
          cs <= pg_down(bl); ce <= pg_up(endr);
        end
      end
      ST_B_START: begin
        i <= CW'(1); mpass <= 1'b0;
        if (lerr) st <= 1'b1;
      end
      ST_SORT_LDW: begin
        cs <= ud_s; ce <= ud_e; m <= i;
      end
      ST_SORT_CHK: if (m == '0) i <= i + CW'(1);
      ST_SORT_CMP: begin
        if (ud_s > cs) m <= mm1;
        else i <= i + CW'(1);
      end
      ST_MRG_0W: begin
        cs <= ud_s; ce <= ud_e; i <= CW'(1); outp <= '0;
      end
      ST_MRG_W: begin
        if (ud_s <= ce) begin
          if (ud_e > ce) ce <= ud_e;
        end else begin
          outp <= outp + CW'(1); cs <= ud_s; ce <= ud_e;
        end
        i <= i + CW'(1);
      end
      ST_MRG_END: begin
        if (!mpass) j <= '0;
        else if (cnt == '0) st <= 1'b1;
        else begin
          i <= '0; sum <= '0;
        end
      end
      ST_CUT_J: if (j >= bcnt) mpass <= 1'b1;
      ST_CUT_JW: begin
        bs <= b_rdata[31:0]; be <= b_rdata[63:32]; i <= '0;
      end
      ST_CUT_I: if (i >= cnt) j <= j + BCW'(1);
      ST_CUT_IW: begin
        cs <= ud_s; ce <= ud_e;
        if (dis) i <= ip1;
        else if (bs <= ud_s) begin
          if (be >= ud_e) m <= ip1;
          else i <= ip1;
        end else if (be >= ud_e) i <= ip1;
        else if (cnt >= CW'(MAX_RANGES)) st <= 1'b1;
        else m <= cnt;
      end
      ST_DROPW: m <= m + CW'(1);
      ST_SPLW: m <= mm1;
      ST_SPL_B: i <= i + CW'(2);
      ST_SUMW: begin
        sum <= sum + ((ud_e - ud_s) >> PAGE_SHIFT);
        i <= ip1;
      end
      ST_AL_CHK: if (hoff) st <= 1'b1;
      ST_AL_LD: if (ptr >= cnt) st <= 1'b1;
      ST_AL_W: if (nxt < ud_e) pa <= nxt;
      ST_AL_NS: if (ptr >= cnt) st <= 1'b1;
      ST_RD: if (32'(idx) >= 32'(cnt)) st <= 1'b1;
      ST_RDW: begin
        rs <= ud_s; re <= ud_e;
        if (32'(idx) < 32'(ptr)) ae <= ud_e;
        else if (32'(idx) == 32'(ptr)) ae <= nxt;
        else ae <= ud_s;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/physical_memory_map_page_allocator.sv @@
// ----------------------------------------------------------------------------
// physical_memory_map_page_allocator: memory map builder and page allocator
// Collects firmware map entries, builds the usable range list, hands out pages.
// ----------------------------------------------------------------------------
// Usage:
//   Send one transaction per item on the s_ channel; tuser carries the
//   operation (map entry, build, allocate page, handoff, read range).
//   Each item returns exactly one transaction on the m_ channel.
//   Write kernel_end_addr via cfg_we/cfg_wdata only while idle; not enforced.
//   A map entry can finish early when it is dropped; an allocate also
//   walks each exhausted range that it skips. Handoff and unknown operations
//   go straight to the result. A build walks the tables through the shared
//   compare unit and one read port per table: sort loads and compares,
//   merge steps, blocked/usable pairs, and entries moved on a drop or a
//   split.
//   The next item is accepted only once the current one is finished.
// Reset:
//   rst (synchronous) clears counters, flags and m_tvalid; m_tdata is kept.
//   Table contents are not cleared; only entries below the counts are read.
// Stall:
//   The result stays in the output register until m_tready; the sequencer
//   may take and work on the next item meanwhile, then waits to hand over.
// ----------------------------------------------------------------------------
module physical_memory_map_page_allocator import pmm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // base_low, base_high, length_low, length_high, entry_type, range_index, pad
  input  logic [167:0] s_tdata,
  // operation
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // page_address, range_start, range_end, allocated_end, total_pages,
  // free_pages, range_count
  output logic [175:0] m_tdata,
  // status
  output logic [0:0]   m_tuser
);

  logic [31:0] kernel_end_addr;
  logic        res_push;
  result_t     res;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end_addr <= '0;
    end else if (cfg_we) begin
      kernel_end_addr <= cfg_wdata;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  pmm_core u_core (
    .clk(clk), .rst(rst), .kernel_end_addr(kernel_end_addr),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
    .in_base_low(s_tdata[31:0]), .in_base_high(s_tdata[63:32]),
    .in_length_low(s_tdata[95:64]), .in_length_high(s_tdata[127:96]),
    .in_entry_type(s_tdata[159:128]), .in_range_index(s_tdata[165:160]),
    .out_free(out_free), .res_push(res_push), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      m_tuser <= res.status;
      m_tdata <= {res.range_count, res.free_pages, res.total_pages,
                  res.allocated_end, res.range_end, res.range_start,
                  res.page_address};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again while item in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[175:170]) <= MAX_RANGES))
    else $error("range count above table size");

  a_page_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[31:0] != 32'd0) |-> !m_tuser[0])
    else $error("page address on failed transaction");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_free)
    else $error("result overwrote a pending transaction");

endmodule
